FILE: hw/rtl/bid_pkg.sv
package bid_pkg;

    localparam int SAMPLE_W = 10;
    localparam int TICK_W   = 16;
    localparam int HOLD_W   = 4;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_ENABLE        = 2'd0,
        REG_DROP_THRESH   = 2'd1,
        REG_LONG_LIMIT    = 2'd2,
        REG_HOLDOFF_TICKS = 2'd3
    } reg_idx_t;

    localparam logic                RST_ENABLE        = 1'b1;
    localparam logic [SAMPLE_W-1:0] RST_DROP_THRESH   = 10'd30;
    localparam logic [TICK_W-1:0]   RST_LONG_LIMIT    = 16'd3000;
    localparam logic [HOLD_W-1:0]   RST_HOLDOFF_TICKS = 4'd10;

    typedef struct packed {
        logic                enable;
        logic [SAMPLE_W-1:0] drop_threshold;
        logic [TICK_W-1:0]   long_interval_limit;
        logic [HOLD_W-1:0]   holdoff_ticks;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN_SCAN,
        ST_WIN_DRAIN,
        ST_DETECT,
        ST_HIST_SCAN,
        ST_HIST_DRAIN,
        ST_DIV_LOAD,
        ST_EST,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic take;
        logic clr_pulse;
        logic win_rd;
        logic detect;
        logic hist_rd;
        logic div_load;
        logic est_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic win_last;
        logic bubble;
        logic long_iv;
        logic hist_last;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/bid_sample_if.sv
interface bid_sample_if import bid_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/bid_result_if.sv
interface bid_result_if import bid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] interval_estimate;
    logic              bubble_pulse;
    logic              indicator_on;

    modport source (output valid, output interval_estimate, output bubble_pulse,
                    output indicator_on, input ready);
    modport sink (input valid, input interval_estimate, input bubble_pulse,
                  input indicator_on, output ready);
endinterface

FILE: hw/rtl/bid_regs.sv
module bid_regs import bid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable              <= RST_ENABLE;
            cfg_reg.drop_threshold      <= RST_DROP_THRESH;
            cfg_reg.long_interval_limit <= RST_LONG_LIMIT;
            cfg_reg.holdoff_ticks       <= RST_HOLDOFF_TICKS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE:        cfg_reg.enable              <= pwdata[0];
                REG_DROP_THRESH:   cfg_reg.drop_threshold      <= pwdata[SAMPLE_W-1:0];
                REG_LONG_LIMIT:    cfg_reg.long_interval_limit <= pwdata[TICK_W-1:0];
                REG_HOLDOFF_TICKS: cfg_reg.holdoff_ticks       <= pwdata[HOLD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE:        prdata = APB_DW'(cfg_reg.enable);
            REG_DROP_THRESH:   prdata = APB_DW'(cfg_reg.drop_threshold);
            REG_LONG_LIMIT:    prdata = APB_DW'(cfg_reg.long_interval_limit);
            REG_HOLDOFF_TICKS: prdata = APB_DW'(cfg_reg.holdoff_ticks);
        endcase
    end

endmodule

FILE: hw/rtl/bid_ctrl.sv
module bid_ctrl import bid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    enable,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clr_pulse = 1'b1;
                    if (enable)
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_WIN_SCAN;
                    end
                    else
                    begin
                        state_next = ST_OUTPUT;
                    end
                end
            end
            ST_WIN_SCAN:
            begin
                cmd.win_rd = 1'b1;
                if (status.win_last)
                begin
                    state_next = ST_WIN_DRAIN;
                end
            end
            ST_WIN_DRAIN:
            begin
                state_next = ST_DETECT;
            end
            ST_DETECT:
            begin
                cmd.detect = 1'b1;
                if (status.bubble && !status.long_iv)
                begin
                    state_next = ST_HIST_SCAN;
                end
                else
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_HIST_SCAN:
            begin
                cmd.hist_rd = 1'b1;
                if (status.hist_last)
                begin
                    state_next = ST_HIST_DRAIN;
                end
            end
            ST_HIST_DRAIN:
            begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_EST;
            end
            ST_EST:
            begin
                cmd.est_load = 1'b1;
                state_next   = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bid_dp.sv
module bid_dp import bid_pkg::*;
#(
    parameter int WINDOW_LEN  = 20,
    parameter int HISTORY_LEN = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TICK_W-1:0]   interval_estimate,
    output logic                bubble_pulse,
    output logic                indicator_on
);

    localparam int WIW = $clog2(WINDOW_LEN);
    localparam int WFW = $clog2(WINDOW_LEN + 1);
    localparam int HIW = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int HFW = $clog2(HISTORY_LEN + 1);
    // sum / HISTORY_LEN == (sum * RECIP) >> RSH for every 16-bit sum
    localparam int RSH = TICK_W + $clog2(HISTORY_LEN);
    localparam int PW  = RSH + TICK_W;
    localparam logic [TICK_W:0] RECIP =
        (TICK_W + 1)'(((64'd1 << RSH) + 64'(HISTORY_LEN) - 64'd1) / 64'(HISTORY_LEN));

    logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
    logic [TICK_W-1:0]   hist_mem [HISTORY_LEN];

    logic [WIW-1:0]      wpos_reg;
    logic [WFW-1:0]      wfill_reg;
    logic [WIW-1:0]      widx_reg;
    logic                wtake_reg;
    logic [SAMPLE_W-1:0] wq_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic [HIW-1:0]      hpos_reg;
    logic [HFW-1:0]      hfill_reg;
    logic [HIW-1:0]      hidx_reg;
    logic                htake_reg;
    logic [TICK_W-1:0]   hq_reg;
    logic [TICK_W-1:0]   sum_reg;

    logic [PW-1:0]       prod_reg;

    logic [TICK_W-1:0]   tick_reg;
    logic [TICK_W-1:0]   last_reg;
    logic                edge_active_reg;
    logic [HOLD_W-1:0]   holdoff_reg;
    logic [TICK_W-1:0]   est_reg;
    logic                pulse_reg;
    logic                out_valid_reg;
    logic [TICK_W-1:0]   out_est_reg;
    logic                out_pulse_reg;
    logic                out_ind_reg;

    logic [SAMPLE_W:0]   drop_sum;
    logic                bubble;
    logic [TICK_W-1:0]   iv;
    logic                ea_now;
    logic [HOLD_W:0]     hold_inc;

    // s < max - threshold with max >= threshold, without a negative difference
    assign drop_sum = {1'b0, sample_reg} + {1'b0, cfg.drop_threshold};
    assign bubble   = (drop_sum < {1'b0, max_reg}) && !edge_active_reg;
    assign iv       = tick_reg - last_reg;
    assign ea_now   = edge_active_reg || bubble;
    assign hold_inc = {1'b0, holdoff_reg} + (HOLD_W + 1)'(1);

    assign status.win_last  = widx_reg == WIW'(WINDOW_LEN - 1);
    assign status.hist_last = hidx_reg == HIW'(HISTORY_LEN - 1);
    assign status.bubble    = bubble;
    assign status.long_iv   = iv > cfg.long_interval_limit;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign interval_estimate = out_est_reg;
    assign bubble_pulse      = out_pulse_reg;
    assign indicator_on      = out_ind_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            win_mem[wpos_reg] <= sample;
        end
        wq_reg <= win_mem[widx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.detect && bubble)
        begin
            hist_mem[hpos_reg] <= iv;
        end
        hq_reg <= hist_mem[hidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= sample;
            max_reg    <= '0;
        end
        else if (wtake_reg && (wq_reg > max_reg))
        begin
            max_reg <= wq_reg;
        end

        if (cmd.detect)
        begin
            sum_reg <= '0;
        end
        else if (htake_reg)
        begin
            sum_reg <= sum_reg + hq_reg;
        end

        if (cmd.div_load)
        begin
            prod_reg <= PW'(sum_reg) * PW'(RECIP);
        end

        if (cmd.out_load)
        begin
            out_est_reg   <= est_reg;
            out_pulse_reg <= pulse_reg;
            out_ind_reg   <= edge_active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg        <= '0;
            wfill_reg       <= '0;
            widx_reg        <= '0;
            wtake_reg       <= 1'b0;
            hpos_reg        <= '0;
            hfill_reg       <= '0;
            hidx_reg        <= '0;
            htake_reg       <= 1'b0;
            tick_reg        <= '0;
            last_reg        <= '0;
            edge_active_reg <= 1'b0;
            holdoff_reg     <= '0;
            est_reg         <= '0;
            pulse_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            wtake_reg <= cmd.win_rd && (WFW'(widx_reg) < wfill_reg);
            htake_reg <= cmd.hist_rd && (HFW'(hidx_reg) < hfill_reg);

            if (cmd.clr_pulse)
            begin
                pulse_reg <= 1'b0;
            end

            if (cmd.take)
            begin
                wpos_reg <= (wpos_reg == WIW'(WINDOW_LEN - 1)) ? '0 : wpos_reg + 1'b1;
                if (wfill_reg != WFW'(WINDOW_LEN))
                begin
                    wfill_reg <= wfill_reg + 1'b1;
                end
                tick_reg <= tick_reg + 1'b1;
                widx_reg <= '0;
            end
            else if (cmd.win_rd)
            begin
                widx_reg <= widx_reg + 1'b1;
            end

            if (cmd.detect)
            begin
                hidx_reg <= '0;
                if (bubble)
                begin
                    pulse_reg <= 1'b1;
                    last_reg  <= tick_reg;
                    hpos_reg  <= (hpos_reg == HIW'(HISTORY_LEN - 1)) ? '0 : hpos_reg + 1'b1;
                    if (hfill_reg != HFW'(HISTORY_LEN))
                    begin
                        hfill_reg <= hfill_reg + 1'b1;
                    end
                    if (iv > cfg.long_interval_limit)
                    begin
                        est_reg <= iv;
                    end
                end
                // holdoff advances on the detection tick as well
                if (ea_now)
                begin
                    if (hold_inc > {1'b0, cfg.holdoff_ticks})
                    begin
                        edge_active_reg <= 1'b0;
                        holdoff_reg     <= '0;
                    end
                    else
                    begin
                        edge_active_reg <= 1'b1;
                        holdoff_reg     <= hold_inc[HOLD_W-1:0];
                    end
                end
            end
            else if (cmd.hist_rd)
            begin
                hidx_reg <= hidx_reg + 1'b1;
            end

            if (cmd.est_load)
            begin
                est_reg <= prod_reg[RSH +: TICK_W];
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/bubble_interval_detector_top.sv
// one result per sample, registered after the window max scan, the bubble detection and, when a
// bubble needs the history average, the history sum, the division and the estimate load; while
// disabled the result is loaded without those steps
// a new sample is taken only once the previous result is loaded: the window max scan
// and the history sum read one entry per cycle; a result still held stalls this further
// rst_n clears all control state and loads the register defaults; the memories are not cleared
module bubble_interval_detector_top import bid_pkg::*;
#(
    parameter int WINDOW_LEN  = 20,
    parameter int HISTORY_LEN = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    bid_sample_if.sink        sample_stream,
    bid_result_if.source      result_stream,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    bid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_stream.valid),
        .in_ready (sample_stream.ready),
        .enable   (cfg.enable),
        .status   (status),
        .cmd      (cmd)
    );

    bid_dp #(
        .WINDOW_LEN  (WINDOW_LEN),
        .HISTORY_LEN (HISTORY_LEN)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .sample            (sample_stream.sample),
        .out_valid         (result_stream.valid),
        .out_ready         (result_stream.ready),
        .interval_estimate (result_stream.interval_estimate),
        .bubble_pulse      (result_stream.bubble_pulse),
        .indicator_on      (result_stream.indicator_on)
    );

    // after a transfer the controller is busy with that sample
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stream.valid && sample_stream.ready |=> !sample_stream.ready)
        else $error("sample taken while previous one still in progress");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_stream.valid || result_stream.ready))
        else $error("output register overwritten before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.win_rd, cmd.detect, cmd.hist_rd, cmd.div_load,
                  cmd.est_load, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule
